[hw/rtl/lcg_uniform_normal_quaternion_generator_core_defines.svh]
// Assertion macros for the LCG generator core.
`ifndef LCG_UNIFORM_NORMAL_QUATERNION_GENERATOR_CORE_DEFINES_SVH
`define LCG_UNIFORM_NORMAL_QUATERNION_GENERATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LUNQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lunq assert");
`define LUNQ_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("lunq never");
`else
`define LUNQ_ASSERT(label, clk, rst_n, prop)
`define LUNQ_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[hw/rtl/lunq_pkg.sv]
`default_nettype none
package lunq_pkg;
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;
  localparam logic [14:0] NORM_LEVELS = 15'd10240;

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_UNIFORM = 2'd1,
    OP_NORMAL  = 2'd2,
    OP_QUAT    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] range_min;
    logic [15:0] range_max;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_UNI_MUL,
    ST_UNI_OUT,
    ST_NORM_DONE,
    ST_NORM_OUT,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_QOUT
  } exe_state_t;
endpackage
`default_nettype wire

[hw/rtl/lunq_if.sv]
`default_nettype none
interface lunq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [15:0] range_min;
  logic signed [15:0] range_max;
  modport source (output valid, op, range_min, range_max, input ready);
  modport sink (input valid, op, range_min, range_max, output ready);
endinterface

interface lunq_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] value;
  logic        last;
  logic        error;
  modport source (output valid, value, last, error, input ready);
  modport sink (input valid, value, last, error, output ready);
endinterface

interface lunq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;
  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface
`default_nettype wire

[hw/rtl/lcg_uniform_normal_quaternion_generator_core.sv]
// One request executes at a time; a two-entry queue buffers further requests.
// Throughput is set by the LCG multiply-then-add step, the serial square root, the divider and output back-pressure.
// The next request leaves the queue the cycle after the last result is accepted.
// Synchronous active-low reset clears the generator state to zero and the queue.
`default_nettype none
module lcg_uniform_normal_quaternion_generator_core #(
  parameter int NORMAL_TERMS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lunq_in_if.sink     in_ch,
  lunq_out_if.source  out_ch,
  lunq_cfg_if.sink    cfg_ch
);
  import lunq_pkg::*;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  assign cfg_ch.ready = 1'b1;

  lunq_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.op), .in_range_min(in_ch.range_min), .in_range_max(in_ch.range_max),
    .q_valid, .q_pop, .q_cmd
  );

  lunq_back #(.NORMAL_TERMS(NORMAL_TERMS)) u_back (
    .clk, .rst_n,
    .cfg_we(cfg_ch.valid), .cfg_seed(cfg_ch.seed),
    .q_valid, .q_pop, .q_cmd,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_value(out_ch.value), .out_last(out_ch.last), .out_error(out_ch.error)
  );
endmodule
`default_nettype wire

[hw/rtl/lunq_front.sv]
`default_nettype none
module lunq_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_op,
  input  wire logic [15:0]    in_range_min,
  input  wire logic [15:0]    in_range_max,
  output logic                q_valid,
  input  wire logic           q_pop,
  output lunq_pkg::cmd_t      q_cmd
);
  import lunq_pkg::*;
  // two-entry queue
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{op: op_t'(in_op), range_min: in_range_min, range_max: in_range_max};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/lunq_back.sv]
`default_nettype none
`include "lcg_uniform_normal_quaternion_generator_core_defines.svh"
module lunq_back #(
  parameter int NORMAL_TERMS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_seed,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire lunq_pkg::cmd_t q_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [15:0]         out_value,
  output logic                out_last,
  output logic                out_error
);
  import lunq_pkg::*;
  localparam int TW = $clog2(NORMAL_TERMS + 1);
  localparam int SW = 14 + TW;
  // floor(S * 32 / (5 * NORMAL_TERMS)) by reciprocal multiply
  localparam longint unsigned NDIV = 64'(5 * NORMAL_TERMS);
  localparam logic [31:0] NMAG = 32'(((64'd1 << 34) + NDIV - 64'd1) / NDIV);

  exe_state_t st_r, st_nxt;
  cmd_t        cmd_r;
  logic [31:0] gen_r;
  logic [31:0] lo_r;
  logic [15:0] hi_r;
  logic [TW-1:0] term_r;
  logic [1:0]  ncnt_r;
  logic [SW-1:0] sum_r;
  logic [5:0]  bit_r;
  logic [15:0] quo_r;
  logic signed [16:0] n_r [4];
  logic [34:0] sq_r;
  logic [34:0] sv_r, sres_r, sbit_r;
  logic [17:0] len_r;
  logic [31:0] dq_r;
  logic [31:0] drem_r;
  logic [31:0] dnum_r;
  logic        dneg_r;
  logic [1:0]  qi_r;
  logic        last_r, err_r;
  logic [33:0] ufrac_r;

  logic [31:0] gen_next;
  logic [14:0] draw;
  logic [31:0] partial;
  logic [49:0] nprod;

  function automatic logic [14:0] draw_mod_n(input logic [31:0] s);
    logic [14:0] d;
    d = s[30:16];
    priority if (d >= 15'(3 * NORM_LEVELS)) return d - 15'(3 * NORM_LEVELS);
    else if (d >= 15'(2 * NORM_LEVELS)) return d - 15'(2 * NORM_LEVELS);
    else if (d >= NORM_LEVELS) return d - NORM_LEVELS;
    else return d;
  endfunction

  function automatic logic [16:0] nabs_q(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  // LCG: 16x32 and 16x16 partial products in ST_MUL, summed in ST_ADD
  assign partial  = 32'(gen_r[15:0] * LCG_MUL);
  assign gen_next = lo_r + {hi_r, 16'd0} + LCG_INC;
  assign draw     = gen_r[30:16];
  assign nprod    = 50'({sum_r, 5'd0} * NMAG);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:      if (q_valid && !out_valid) st_nxt = ST_MUL;
      ST_MUL:       st_nxt = ST_ADD;
      ST_ADD: begin
        unique case (cmd_r.op)
          OP_RAW:     st_nxt = ST_UNI_OUT;
          OP_UNIFORM: st_nxt = ST_UNI_MUL;
          default:    st_nxt = (32'(term_r) + 1 == NORMAL_TERMS) ? ST_NORM_DONE : ST_MUL;
        endcase
      end
      ST_UNI_MUL:   st_nxt = ST_UNI_OUT;
      ST_UNI_OUT:   st_nxt = ST_IDLE;
      ST_NORM_DONE: st_nxt = ST_NORM_OUT;
      ST_NORM_OUT: begin
        if (cmd_r.op == OP_NORMAL) st_nxt = ST_IDLE;
        else if (ncnt_r == 2'd3) st_nxt = ST_SQ;
        else st_nxt = ST_MUL;
      end
      ST_SQ:        st_nxt = (ncnt_r == 2'd3) ? ST_SQRT : ST_SQ;
      ST_SQRT:      st_nxt = (sbit_r == 35'd0) ? ST_DIV : ST_SQRT;
      ST_DIV:       st_nxt = (len_r == 18'd0 || bit_r == 6'd0) ? ST_QOUT : ST_DIV;
      ST_QOUT: begin
        if (out_valid) st_nxt = ST_QOUT;
        else if (qi_r == 2'd3) st_nxt = ST_IDLE;
        else st_nxt = ST_DIV;
      end
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == ST_IDLE) && q_valid && !out_valid;
  end

  logic signed [16:0] nsel;
  logic [16:0] nabs;
  assign nsel = n_r[ncnt_r];
  assign nabs = nsel[16] ? 17'(-nsel) : 17'(nsel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      gen_r     <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        gen_r <= cfg_seed;
      end else if (st_r == ST_ADD) begin
        gen_r <= gen_next;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            cmd_r  <= q_cmd;
            term_r <= '0;
            ncnt_r <= 2'd0;
            sum_r  <= '0;
          end
        end
        ST_MUL: begin
          lo_r <= partial;
          hi_r <= 16'(gen_r[31:16] * LCG_MUL[15:0]);
        end
        ST_ADD: begin
          term_r <= term_r + 1'b1;
        end
        ST_UNI_MUL: begin
          ufrac_r <= 34'($signed({1'b0, draw[9:0]}) *
                     ($signed({cmd_r.range_max[15], cmd_r.range_max}) -
                      $signed({cmd_r.range_min[15], cmd_r.range_min})));
        end
        ST_UNI_OUT: begin
          out_valid <= 1'b1;
          out_last  <= 1'b1;
          out_error <= 1'b0;
          if (cmd_r.op == OP_RAW) out_value <= {1'b0, draw};
          else out_value <= 16'(cmd_r.range_min + ufrac_r[25:10]);
        end
        default: ;
      endcase
      if (st_r == ST_ADD && (cmd_r.op == OP_NORMAL || cmd_r.op == OP_QUAT)) begin
        sum_r <= sum_r + SW'(draw_mod_n(gen_next));
      end
      if (st_r == ST_NORM_DONE) begin
        quo_r <= nprod[49:34];
      end
      if (st_r == ST_NORM_OUT) begin
        term_r <= '0;
        sum_r  <= '0;
        if (cmd_r.op == OP_NORMAL) begin
          out_valid <= 1'b1;
          out_last  <= 1'b1;
          out_error <= 1'b0;
          out_value <= quo_r ^ 16'h8000;
        end else begin
          n_r[ncnt_r] <= 17'($signed({1'b0, quo_r}) - 17'sd32768);
          ncnt_r <= ncnt_r + 1'b1;
          if (ncnt_r == 2'd3) sq_r <= '0;
        end
      end
      if (st_r == ST_SQ) begin
        sq_r   <= sq_r + 35'(nabs * nabs);
        ncnt_r <= ncnt_r + 1'b1;
        if (ncnt_r == 2'd3) begin
          sv_r   <= sq_r + 35'(nabs * nabs);
          sres_r <= '0;
          sbit_r <= 35'd1 << 34;
        end
      end
      if (st_r == ST_SQRT) begin
        if (sbit_r != 35'd0) begin
          if (sv_r >= sres_r + sbit_r) begin
            sv_r   <= sv_r - (sres_r + sbit_r);
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end else begin
          len_r <= sres_r[17:0];
          qi_r  <= 2'd0;
          bit_r <= 6'd32;
          dnum_r <= 32'(nabs_q(n_r[0])) << 14;
          dneg_r <= n_r[0][16];
          drem_r <= '0;
          dq_r   <= '0;
        end
      end
      if (st_r == ST_DIV && len_r != 18'd0 && bit_r != 6'd0) begin
        dnum_r <= dnum_r << 1;
        bit_r  <= bit_r - 1'b1;
        if ({drem_r[30:0], dnum_r[31]} >= {14'd0, len_r}) begin
          drem_r <= {drem_r[30:0], dnum_r[31]} - {14'd0, len_r};
          dq_r   <= {dq_r[30:0], 1'b1};
        end else begin
          drem_r <= {drem_r[30:0], dnum_r[31]};
          dq_r   <= {dq_r[30:0], 1'b0};
        end
      end
      if (st_r == ST_QOUT && !out_valid) begin
        out_valid <= 1'b1;
        out_last  <= (qi_r == 2'd3);
        out_error <= (len_r == 18'd0);
        out_value <= (len_r == 18'd0) ? 16'd0 : (dneg_r ? 16'(-dq_r) : dq_r[15:0]);
        qi_r   <= qi_r + 1'b1;
        bit_r  <= 6'd32;
        dnum_r <= 32'(nabs_q(n_r[qi_r + 2'd1])) << 14;
        dneg_r <= n_r[qi_r + 2'd1][16];
        drem_r <= '0;
        dq_r   <= '0;
      end
    end
  end

  `LUNQ_ASSERT(a_single_last, clk, rst_n, (out_valid && cmd_r.op != OP_QUAT) |-> out_last)
  `LUNQ_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> (st_r == ST_IDLE))
  `LUNQ_ASSERT_NEVER(a_err_nonzero, clk, rst_n, out_valid && out_error && out_value != 16'd0)
endmodule
`default_nettype wire

[verif/tb_top.sv]
module tb_top;
  import lunq_pkg::*;

  localparam int N_TERMS   = 16;
  localparam int WD_LIMIT  = 4000;
  localparam int HOLD_LEN  = 400;
  localparam int N_RANDOM  = 104;
  localparam int N_DIR     = 18;

  typedef struct {
    logic [15:0] value;
    logic        last;
    logic        error;
  } sample_t;

  typedef struct {
    op_t         op;
    logic [15:0] lo;
    logic [15:0] hi;
    bit          known;
    logic [15:0] val;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lunq_in_if  in_if ();
  lunq_out_if out_if ();
  lunq_cfg_if cfg_if ();

  lcg_uniform_normal_quaternion_generator_core #(
    .NORMAL_TERMS(N_TERMS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  logic [31:0] lcg_state;
  sample_t     pending_samples[$];
  sample_t     typed_vals[$];
  int          errors;
  int          in_accepts;
  int          idle_cycles;
  bit          calm;

  dir_row_t dir_rows [N_DIR] = '{
    '{OP_RAW,     16'h0000, 16'h0000, 1'b1, 16'h0000},
    '{OP_UNIFORM, 16'h8000, 16'h8000, 1'b1, 16'h8000},
    '{OP_UNIFORM, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF},
    '{OP_UNIFORM, 16'h0000, 16'h0000, 1'b1, 16'h0000},
    '{OP_UNIFORM, 16'h8000, 16'h7FFF, 1'b0, 16'h0000},
    '{OP_UNIFORM, 16'h7FFF, 16'h8000, 1'b0, 16'h0000},
    '{OP_UNIFORM, 16'h1000, 16'hF000, 1'b0, 16'h0000},
    '{OP_UNIFORM, 16'hF000, 16'h1000, 1'b0, 16'h0000},
    '{OP_UNIFORM, 16'h0000, 16'h0001, 1'b0, 16'h0000},
    '{OP_RAW,     16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_RAW,     16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{OP_NORMAL,  16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{OP_NORMAL,  16'hFFFF, 16'h8000, 1'b0, 16'h0000},
    '{OP_QUAT,    16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{OP_QUAT,    16'h7FFF, 16'h8000, 1'b0, 16'h0000},
    '{OP_UNIFORM, 16'hFFFF, 16'h0000, 1'b0, 16'h0000},
    '{OP_RAW,     16'h0000, 16'h0000, 1'b0, 16'h0000},
    '{OP_NORMAL,  16'h1234, 16'h4321, 1'b0, 16'h0000}
  };

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [14:0] lcg_draw();
    lcg_state = lcg_state * LCG_MUL + LCG_INC;
    return lcg_state[30:16];
  endfunction

  function automatic longint normal_draw();
    longint sum;
    sum = 0;
    for (int i = 0; i < N_TERMS; i++) begin
      sum += longint'(lcg_draw()) % 10240;
    end
    return (sum * 65536) / (10240 * N_TERMS) - 32768;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic predict_samples(op_t op, logic [15:0] lo_bits, logic [15:0] hi_bits);
    longint lo, hi, frac, v, n[4];
    longint unsigned sq, len;
    sample_t s;
    lo = longint'($signed(lo_bits));
    hi = longint'($signed(hi_bits));
    s.last = 1'b1;
    s.error = 1'b0;
    case (op)
      OP_RAW: begin
        s.value = {1'b0, lcg_draw()};
        pending_samples.push_back(s);
      end
      OP_UNIFORM: begin
        frac = longint'(lcg_draw()) % 1024;
        v = lo + ((frac * (hi - lo)) >>> 10);
        s.value = v[15:0];
        pending_samples.push_back(s);
      end
      OP_NORMAL: begin
        v = normal_draw();
        s.value = v[15:0];
        pending_samples.push_back(s);
      end
      default: begin
        sq = 0;
        for (int i = 0; i < 4; i++) begin
          n[i] = normal_draw();
          sq += longint'(n[i] * n[i]);
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 4; i++) begin
          v = (len != 0) ? (n[i] * 16384) / longint'(len) : 0;
          s.value = v[15:0];
          s.last = (i == 3);
          s.error = (len == 0);
          pending_samples.push_back(s);
        end
      end
    endcase
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // monitor: prediction at input transaction, compare at output transaction
  always @(posedge clk) begin
    sample_t s, t;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) lcg_state = cfg_if.seed;
      if (in_if.valid && in_if.ready) begin
        int base;
        base = pending_samples.size();
        predict_samples(op_t'(in_if.op), in_if.range_min, in_if.range_max);
        if (typed_vals.size() > 0) begin
          t = typed_vals.pop_front();
          if (t.last) pending_samples[base].value = t.value;
        end
        in_accepts++;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_samples.size() == 0) begin
          report("unexpected transaction", out_if.value, 16'h0);
        end else begin
          s = pending_samples.pop_front();
          if (out_if.value !== s.value) report("value", out_if.value, s.value);
          if (out_if.last !== s.last) report("last", 16'(out_if.last), 16'(s.last));
          if (out_if.error !== s.error) report("error", 16'(out_if.error), 16'(s.error));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && in_accepts >= 40) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  task automatic write_seed(logic [31:0] seed);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.seed <= seed;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_item(op_t op, logic [15:0] lo, logic [15:0] hi);
    while (!calm && $urandom_range(0, 99) < 36) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.range_min <= lo;
    in_if.range_max <= hi;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    sample_t t;
    op_t op;
    logic [15:0] lo, hi;
    errors = 0;
    in_accepts = 0;
    calm = 1'b0;
    lcg_state = '0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_RAW;
    in_if.range_min = '0;
    in_if.range_max = '0;
    cfg_if.valid = 1'b0;
    cfg_if.seed = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      t.value = dir_rows[i].val;
      t.last = dir_rows[i].known;
      t.error = 1'b0;
      typed_vals.push_back(t);
      send_item(dir_rows[i].op, dir_rows[i].lo, dir_rows[i].hi);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_seed(32'hFFFF_FFFF);
        1: write_seed(32'h0000_0000);
        default: write_seed($urandom());
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        calm = (phase == 2);
        case ($urandom_range(0, 9))
          0, 1, 2: op = OP_RAW;
          3, 4, 5: op = OP_UNIFORM;
          6, 7: op = OP_NORMAL;
          default: op = OP_QUAT;
        endcase
        lo = rand_bound();
        hi = ($urandom_range(0, 9) == 0) ? lo : rand_bound();
        send_item(op, lo, hi);
      end
      calm = 1'b0;
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lunq_pkg.sv
hw/rtl/lunq_if.sv
hw/rtl/lunq_front.sv
hw/rtl/lunq_back.sv
hw/rtl/lcg_uniform_normal_quaternion_generator_core.sv
verif/tb_top.sv
